>>> hw/rtl/ctdc_pkg.sv
// ctdc_pkg: shared types, event codes, mode codes and segment tables
// for the countdown timer display controller; no dependencies
`timescale 1ns / 1ps

package ctdc_pkg;

    // event codes carried in func
    localparam logic [3:0] FuncTick      = 4'd0;
    localparam logic [3:0] FuncStartLow  = 4'd1;
    localparam logic [3:0] FuncStartHigh = 4'd2;
    localparam logic [3:0] FuncMode      = 4'd3;
    localparam logic [3:0] FuncUp        = 4'd4;
    localparam logic [3:0] FuncDown      = 4'd5;
    localparam logic [3:0] FuncUpRep     = 4'd6;
    localparam logic [3:0] FuncDownRep   = 4'd7;
    localparam logic [3:0] FuncLoad      = 4'd8;

    // operating modes
    localparam logic [1:0] ModeIdle = 2'd0;
    localparam logic [1:0] ModeRun  = 2'd1;
    localparam logic [1:0] ModeSet  = 2'd2;

    // display scan positions
    localparam logic [1:0] DigitHund  = 2'd0;
    localparam logic [1:0] DigitTens  = 2'd1;
    localparam logic [1:0] DigitUnits = 2'd2;

    // register indexes on the config port
    localparam logic RegCountInterval = 1'b0;
    localparam logic RegBlinkInterval = 1'b1;

    localparam logic [9:0]  MaxValue          = 10'd999;
    localparam logic [15:0] CountIntervalInit = 16'd95;
    localparam logic [15:0] BlinkIntervalInit = 16'd300;

    typedef struct packed {
        logic [3:0] func;
        logic [9:0] preset_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] port_a_out;
        logic [7:0] port_b_out;
        logic [7:0] port_c_out;
        logic [7:0] port_d_out;
        logic [7:0] port_d_dir;
        logic [1:0] mode_out;
        logic [9:0] count_out;
        logic       save_valid;
        logic [9:0] save_value;
    } t_out_item;

    typedef struct packed {
        logic [15:0] count_interval;
        logic [15:0] blink_interval;
    } t_cfg;

    // state needed to draw one display digit
    typedef struct packed {
        logic [9:0] count;
        logic [1:0] digit;
        logic       blink_on;
        logic       running;
    } t_scan_req;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] d;
        logic [7:0] dir;
    } t_port_bytes;

    // board segment tables, indexed by digit value
    function automatic logic [7:0] seg_tab_b(input logic [3:0] n);
        logic [7:0] v;
        case (n)
            4'd0: v = 8'hCF;
            4'd1, 4'd2, 4'd3, 4'd7: v = 8'h10;
            4'd5, 4'd6: v = 8'h20;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] seg_tab_c(input logic [3:0] n);
        logic [7:0] v;
        case (n)
            4'd0: v = 8'h47;
            4'd1: v = 8'h78;
            4'd2: v = 8'hC0;
            4'd3: v = 8'h50;
            4'd4: v = 8'h78;
            4'd5: v = 8'h50;
            4'd6: v = 8'h40;
            4'd7: v = 8'h70;
            4'd8: v = 8'h40;
            4'd9: v = 8'h50;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] seg_tab_d(input logic [3:0] n);
        logic [7:0] v;
        case (n)
            4'd0, 4'd1, 4'd7: v = 8'h04;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] seg_tab_dir(input logic [3:0] n);
        logic [7:0] v;
        case (n)
            4'd0, 4'd1, 4'd7: v = 8'h42;
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9: v = 8'h46;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/ctdc_apb.sv
// ctdc_apb: apb-style register file for the count and blink intervals
// depends on ctdc_pkg
`timescale 1ns / 1ps

module ctdc_apb (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output ctdc_pkg::t_cfg       o_cfg
);
    import ctdc_pkg::*;

    logic [15:0] r_count_interval;
    logic [15:0] r_blink_interval;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // register writes, index from the word address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_interval <= CountIntervalInit;
            r_blink_interval <= BlinkIntervalInit;
        end else if (wr_en) begin
            unique case (paddr[2])
                RegCountInterval: r_count_interval <= pwdata[15:0];
                RegBlinkInterval: r_blink_interval <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            RegCountInterval: prdata = {16'd0, r_count_interval};
            RegBlinkInterval: prdata = {16'd0, r_blink_interval};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg.count_interval = r_count_interval;
    assign o_cfg.blink_interval = r_blink_interval;

endmodule

>>> hw/rtl/ctdc_scan.sv
// ctdc_scan: splits the count into decimal digits and builds the five
// port bytes for the scanned digit; depends on ctdc_pkg
`timescale 1ns / 1ps

module ctdc_scan (
    input  ctdc_pkg::t_scan_req   i_req,
    output ctdc_pkg::t_port_bytes o_bytes
);
    import ctdc_pkg::*;

    logic [15:0] prod_h;
    logic [17:0] prod_t;
    logic [3:0]  hund;
    logic [6:0]  quot10;
    logic [6:0]  tens_w;
    logic [9:0]  units_w;
    logic [3:0]  digit_val;
    logic        sel1;
    logic        sel2;
    logic        sel3;
    logic        point;

    // reciprocal multiply: x*41>>12 = x/100 and x*205>>11 = x/10 for x <= 999
    assign prod_h  = 16'(i_req.count) * 16'd41;
    assign prod_t  = 18'(i_req.count) * 18'd205;
    assign hund    = prod_h[15:12];
    assign quot10  = prod_t[17:11];
    assign tens_w  = quot10 - 7'(hund) * 7'd10;
    assign units_w = i_req.count - 10'(quot10) * 10'd10;

    // digit select and point follow the blink flag
    always_comb begin
        sel1      = 1'b0;
        sel2      = 1'b0;
        sel3      = 1'b0;
        point     = 1'b0;
        digit_val = hund;
        unique case (i_req.digit)
            DigitTens: begin
                digit_val = tens_w[3:0];
                sel2      = i_req.blink_on;
                point     = i_req.blink_on;
            end
            DigitUnits: begin
                digit_val = units_w[3:0];
                sel3      = i_req.blink_on;
            end
            // unreachable fourth position shows the hundreds digit
            default: begin
                digit_val = hund;
                sel1      = i_req.blink_on;
            end
        endcase
    end

    // table lookup and bit merge
    assign o_bytes.a   = {5'd0, sel3, sel2, 1'b0};
    assign o_bytes.b   = seg_tab_b(digit_val);
    assign o_bytes.c   = seg_tab_c(digit_val) & ~{1'b0, point, 6'd0};
    assign o_bytes.d   = seg_tab_d(digit_val) | {1'b0, sel1, 4'd0, i_req.running, 1'b0};
    assign o_bytes.dir = seg_tab_dir(digit_val);

endmodule

>>> hw/rtl/ctdc_ctrl.sv
// ctdc_ctrl: timer state, event handling and next result for one transaction
// depends on ctdc_pkg and ctdc_scan
`timescale 1ns / 1ps

module ctdc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  ctdc_pkg::t_in_item   i_item,
    input  ctdc_pkg::t_cfg       i_cfg,
    output ctdc_pkg::t_out_item  o_result
);
    import ctdc_pkg::*;

    logic [1:0]  r_mode,        n_mode;
    logic        r_start_latch, n_start_latch;
    logic [9:0]  r_count,       n_count;
    logic [9:0]  r_preset,      n_preset;
    logic [15:0] r_tick_cnt,    n_tick_cnt;
    logic [15:0] r_blink_cnt,   n_blink_cnt;
    logic        r_blink_on,    n_blink_on;
    logic [1:0]  r_scan_digit,  n_scan_digit;
    t_port_bytes r_port_hold,   n_port_hold;

    t_scan_req   scan_req;
    t_port_bytes scan_bytes;
    logic [15:0] tick_inc;
    logic [15:0] blink_inc;
    logic [9:0]  preset_up;
    logic [9:0]  preset_down;
    logic [9:0]  load_val;
    logic        save;

    // digit drawing from the state before this event
    assign scan_req.count    = r_count;
    assign scan_req.digit    = r_scan_digit;
    assign scan_req.blink_on = r_blink_on;
    assign scan_req.running  = (r_mode == ModeRun);

    ctdc_scan u_scan (
        .i_req   (scan_req),
        .o_bytes (scan_bytes)
    );

    assign tick_inc    = r_tick_cnt + 16'd1;
    assign blink_inc   = r_blink_cnt + 16'd1;
    assign preset_up   = (r_preset >= MaxValue) ? 10'd0 : r_preset + 10'd1;
    assign preset_down = (r_preset == 10'd0 || r_preset > MaxValue) ? MaxValue
                                                                    : r_preset - 10'd1;
    assign load_val    = (i_item.preset_in > MaxValue) ? MaxValue : i_item.preset_in;

    // event decode and next state
    always_comb begin
        n_mode        = r_mode;
        n_start_latch = r_start_latch;
        n_count       = r_count;
        n_preset      = r_preset;
        n_tick_cnt    = r_tick_cnt;
        n_blink_cnt   = r_blink_cnt;
        n_blink_on    = r_blink_on;
        n_scan_digit  = r_scan_digit;
        n_port_hold   = r_port_hold;
        save          = 1'b0;
        case (i_item.func) inside
            FuncTick: begin
                n_tick_cnt   = tick_inc;
                n_blink_cnt  = blink_inc;
                n_port_hold  = scan_bytes;
                n_scan_digit = (r_scan_digit >= DigitUnits) ? DigitHund
                                                            : r_scan_digit + 2'd1;
                if (r_mode == ModeSet && blink_inc > i_cfg.blink_interval) begin
                    n_blink_cnt = 16'd0;
                    n_blink_on  = ~r_blink_on;
                end
                if (r_mode == ModeRun && tick_inc > i_cfg.count_interval) begin
                    n_tick_cnt = 16'd0;
                    if (r_count <= 10'd1) begin
                        n_count = r_preset;
                        n_mode  = ModeIdle;
                    end else begin
                        n_count = r_count - 10'd1;
                    end
                end
            end
            FuncStartLow: begin
                if (r_mode == ModeIdle && !r_start_latch) begin
                    n_mode        = ModeRun;
                    n_start_latch = 1'b1;
                end
            end
            FuncStartHigh: begin
                if (r_mode == ModeIdle) begin
                    n_start_latch = 1'b0;
                end
            end
            FuncMode: begin
                if (r_mode != ModeRun) begin
                    n_count = r_preset;
                    if (r_mode == ModeSet) begin
                        n_mode     = ModeIdle;
                        n_blink_on = 1'b1;
                    end else if (r_mode == ModeIdle) begin
                        n_mode = ModeSet;
                    end
                end
            end
            FuncUp, FuncUpRep: begin
                if (r_mode == ModeSet) begin
                    n_preset   = preset_up;
                    n_count    = preset_up;
                    n_blink_on = 1'b1;
                    save       = 1'b1;
                end
            end
            FuncDown, FuncDownRep: begin
                if (r_mode == ModeSet) begin
                    n_preset   = preset_down;
                    n_count    = preset_down;
                    n_blink_on = 1'b1;
                    save       = 1'b1;
                end
            end
            FuncLoad: begin
                n_preset = load_val;
                n_count  = load_val;
            end
            default: ;
        endcase
    end

    // state registers, updated once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= ModeIdle;
            r_start_latch <= 1'b0;
            r_count       <= 10'd0;
            r_preset      <= 10'd0;
            r_tick_cnt    <= 16'd0;
            r_blink_cnt   <= 16'd0;
            r_blink_on    <= 1'b1;
            r_scan_digit  <= DigitHund;
            r_port_hold   <= '0;
        end else if (i_accept) begin
            r_mode        <= n_mode;
            r_start_latch <= n_start_latch;
            r_count       <= n_count;
            r_preset      <= n_preset;
            r_tick_cnt    <= n_tick_cnt;
            r_blink_cnt   <= n_blink_cnt;
            r_blink_on    <= n_blink_on;
            r_scan_digit  <= n_scan_digit;
            r_port_hold   <= n_port_hold;
        end
    end

    // result fields after the event
    assign o_result.port_a_out = n_port_hold.a;
    assign o_result.port_b_out = n_port_hold.b;
    assign o_result.port_c_out = n_port_hold.c;
    assign o_result.port_d_out = n_port_hold.d;
    assign o_result.port_d_dir = n_port_hold.dir;
    assign o_result.mode_out   = n_mode;
    assign o_result.count_out  = n_count;
    assign o_result.save_valid = save;
    assign o_result.save_value = save ? n_preset : 10'd0;

    // scan position wraps after the units digit
    a_scan_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.func == FuncTick && r_scan_digit == DigitUnits)
        |=> (r_scan_digit == DigitHund))
        else $error("scan position did not wrap after units digit");

    // count and preset stay in display range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= MaxValue) && (r_preset <= MaxValue))
        else $error("count or preset out of range");

    // an edit in setting mode leaves count equal to preset
    a_edit_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && save) |=> (r_count == r_preset && r_blink_on))
        else $error("count does not follow edited preset");

endmodule

>>> hw/rtl/countdown_timer_display_controller_core.sv
// countdown_timer_display_controller_core: top level with event channel,
// result register and config port; depends on ctdc_pkg, ctdc_apb, ctdc_ctrl
// latency: a result is registered at the accepting edge and shown the next cycle
// throughput: one event per cycle when not stalled, set by the single result register and
//   the state update in ctdc_ctrl; input ready stays high while the result is taken
// reset (i_rst_n, synchronous, active low): idle mode, count and preset zero,
//   blink flag set, port bytes zero, intervals 95 and 300, no result pending
`timescale 1ns / 1ps

module countdown_timer_display_controller_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ctdc_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ctdc_pkg::t_out_item   o_out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import ctdc_pkg::*;

    t_cfg      cfg;
    t_out_item result;
    logic      in_accept;
    logic      r_out_valid;
    t_out_item r_out_item;

    // accept when the result register is free or being emptied
    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign in_accept  = i_in_valid & o_in_ready;

    ctdc_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ctdc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // a save request only comes out of setting mode
    a_save_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.save_valid) |-> (o_out_item.mode_out == ModeSet))
        else $error("save request outside setting mode");

    // each accepted transaction leaves a pending result
    a_result_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted transaction produced no result");

    // no save value without a save request
    a_save_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.save_valid) |-> (o_out_item.save_value == 10'd0))
        else $error("save value set without save request");

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking testbench for countdown_timer_display_controller_core;
// drives events and apb register writes, predicts each result frame and checks it
// depends on ctdc_pkg and the core rtl only
`timescale 1ns / 1ps

module tb_top;

    import ctdc_pkg::*;

    localparam int unsigned CycleLimit = 400000;
    localparam int DirRows = 25;
    localparam int MaxPrints = 40;

    // board segment tables, indexed by digit value
    localparam logic [7:0] SegB [10] = '{8'hCF, 8'h10, 8'h10, 8'h10, 8'h00,
                                         8'h20, 8'h20, 8'h10, 8'h00, 8'h00};
    localparam logic [7:0] SegC [10] = '{8'h47, 8'h78, 8'hC0, 8'h50, 8'h78,
                                         8'h50, 8'h40, 8'h70, 8'h40, 8'h50};
    localparam logic [7:0] SegD [10] = '{8'h04, 8'h04, 8'h00, 8'h00, 8'h00,
                                         8'h00, 8'h00, 8'h04, 8'h00, 8'h00};
    localparam logic [7:0] SegDir [10] = '{8'h42, 8'h42, 8'h46, 8'h46, 8'h46,
                                           8'h46, 8'h46, 8'h42, 8'h46, 8'h46};

    // one row of the directed table; typed rows carry a frame with all ports zero
    typedef struct packed {
        logic [3:0] func;
        logic [9:0] pin;
        logic       typed;
        logic [1:0] mode;
        logic [9:0] count;
    } t_dir_row;

    localparam t_dir_row DirTab [DirRows] = '{
        '{FuncStartHigh, 10'd0,    1'b1, ModeIdle, 10'd0},
        '{FuncLoad,      10'd1023, 1'b1, ModeIdle, 10'd999},
        '{FuncTick,      10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncTick,      10'd512,  1'b0, ModeIdle, 10'd0},
        '{FuncTick,      10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncLoad,      10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncDown,      10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncMode,      10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncDown,      10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncUp,        10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncUpRep,     10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncDownRep,   10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncTick,      10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncMode,      10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncLoad,      10'd2,    1'b0, ModeIdle, 10'd0},
        '{FuncStartLow,  10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncStartLow,  10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncStartHigh, 10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncMode,      10'd0,    1'b0, ModeIdle, 10'd0},
        '{4'd15,         10'd1023, 1'b0, ModeIdle, 10'd0},
        '{FuncTick,      10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncTick,      10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncTick,      10'd0,    1'b0, ModeIdle, 10'd0},
        '{FuncLoad,      10'd7,    1'b0, ModeIdle, 10'd0},
        '{FuncUp,        10'd0,    1'b0, ModeIdle, 10'd0}
    };

    // dut signals
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // timer state as the predictor sees it
    logic [1:0]  timer_mode = ModeIdle;
    logic        start_held = 1'b0;
    logic [9:0]  cur_count = '0;
    logic [9:0]  cur_preset = '0;
    logic [15:0] tick_cnt = '0;
    logic [15:0] blink_cnt = '0;
    logic        blink_lit = 1'b1;
    logic [1:0]  scan_pos = DigitHund;
    t_port_bytes held_ports = '0;
    logic [15:0] cfg_count_ivl = CountIntervalInit;
    logic [15:0] cfg_blink_ivl = BlinkIntervalInit;

    t_out_item   frames_due [$];
    int          errors = 0;
    int          burst_left = 1;
    int unsigned cycle_cnt = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          rx_style = 0;
    int unsigned rx_cycles = 0;

    countdown_timer_display_controller_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CycleLimit) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (errors < MaxPrints)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch(what, longint'(got), longint'(want));
    endtask

    // apply one event to the timer state and build the frame it returns
    task automatic advance_timer(input t_in_item ev, output t_out_item frame);
        logic saved;
        int   dig;
        logic d1, d2, d3, dp;
        saved = 1'b0;
        d1 = 1'b0;
        d2 = 1'b0;
        d3 = 1'b0;
        dp = 1'b0;
        case (ev.func)
            FuncTick: begin
                tick_cnt = tick_cnt + 16'd1;
                blink_cnt = blink_cnt + 16'd1;
                // draw the scanned digit from the count before this tick
                case (scan_pos)
                    DigitTens: begin
                        dig = (cur_count / 10) % 10;
                        d2 = blink_lit;
                        dp = blink_lit;
                    end
                    DigitUnits: begin
                        dig = cur_count % 10;
                        d3 = blink_lit;
                    end
                    default: begin
                        dig = (cur_count / 100) % 10;
                        d1 = blink_lit;
                    end
                endcase
                held_ports.a = {5'b0, d3, d2, 1'b0};
                held_ports.b = SegB[dig];
                held_ports.c = SegC[dig] & ~{1'b0, dp, 6'b0};
                held_ports.d = SegD[dig] | {1'b0, d1, 4'b0, timer_mode == ModeRun, 1'b0};
                held_ports.dir = SegDir[dig];
                scan_pos = (scan_pos >= DigitUnits) ? DigitHund : scan_pos + 2'd1;
                if (timer_mode == ModeSet && blink_cnt > cfg_blink_ivl) begin
                    blink_cnt = '0;
                    blink_lit = ~blink_lit;
                end
                // count down, reload the preset and go idle once it runs out
                if (timer_mode == ModeRun && tick_cnt > cfg_count_ivl) begin
                    tick_cnt = '0;
                    if (cur_count <= 10'd1) begin
                        cur_count = cur_preset;
                        timer_mode = ModeIdle;
                    end else begin
                        cur_count = cur_count - 10'd1;
                    end
                end
            end
            FuncStartLow: begin
                if (timer_mode == ModeIdle && !start_held) begin
                    timer_mode = ModeRun;
                    start_held = 1'b1;
                end
            end
            FuncStartHigh: begin
                if (timer_mode == ModeIdle && start_held)
                    start_held = 1'b0;
            end
            FuncMode: begin
                if (timer_mode != ModeRun) begin
                    cur_count = cur_preset;
                    if (timer_mode == ModeSet) begin
                        timer_mode = ModeIdle;
                        blink_lit = 1'b1;
                    end else if (timer_mode == ModeIdle) begin
                        timer_mode = ModeSet;
                    end
                end
            end
            FuncUp, FuncUpRep, FuncDown, FuncDownRep: begin
                // preset edits wrap over the display range
                if (timer_mode == ModeSet) begin
                    if (ev.func == FuncUp || ev.func == FuncUpRep)
                        cur_preset = (cur_preset >= MaxValue) ? 10'd0 : cur_preset + 10'd1;
                    else if (cur_preset == 10'd0 || cur_preset > MaxValue)
                        cur_preset = MaxValue;
                    else
                        cur_preset = cur_preset - 10'd1;
                    blink_lit = 1'b1;
                    cur_count = cur_preset;
                    saved = 1'b1;
                end
            end
            FuncLoad: begin
                cur_preset = (ev.preset_in > MaxValue) ? MaxValue : ev.preset_in;
                cur_count = cur_preset;
            end
            default: begin
            end
        endcase
        frame.port_a_out = held_ports.a;
        frame.port_b_out = held_ports.b;
        frame.port_c_out = held_ports.c;
        frame.port_d_out = held_ports.d;
        frame.port_d_dir = held_ports.dir;
        frame.mode_out = timer_mode;
        frame.count_out = cur_count;
        frame.save_valid = saved;
        frame.save_value = saved ? cur_preset : 10'd0;
    endtask

    // offer one event and hold it until the transaction completes
    task automatic send_event(input t_in_item ev, input logic typed, input t_out_item typed_frame);
        t_out_item frame;
        i_in_valid <= 1'b1;
        i_in_item <= ev;
        do @(posedge i_clk); while (!o_in_ready);
        advance_timer(ev, frame);
        frames_due.push_back(typed ? typed_frame : frame);
    endtask

    // drop the input valid and wait for every outstanding frame
    task automatic drain_frames();
        i_in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // apb write followed by a read back of the same register
    task automatic cfg_write(input logic addr_sel, input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {addr_sel, 2'b00};
        pwdata <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr_sel == RegBlinkInterval)
            cfg_blink_ivl = value;
        else
            cfg_count_ivl = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("register read back", prdata[15:0], value);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // random events in bursts; mostly ticks and buttons, some loads and unused codes
    task automatic send_random(input int n, input int gap_max);
        t_in_item ev;
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            ev.preset_in = 10'($urandom_range(0, 1023));
            if (pick < 50)
                ev.func = FuncTick;
            else if (pick < 56)
                ev.func = FuncStartLow;
            else if (pick < 62)
                ev.func = FuncStartHigh;
            else if (pick < 68)
                ev.func = FuncMode;
            else if (pick < 74)
                ev.func = FuncUp;
            else if (pick < 80)
                ev.func = FuncDown;
            else if (pick < 84)
                ev.func = FuncUpRep;
            else if (pick < 88)
                ev.func = FuncDownRep;
            else if (pick < 96)
                ev.func = FuncLoad;
            else
                ev.func = 4'($urandom_range(FuncLoad + 1, 15));
            // short presets most of the time so countdowns run out
            if (ev.func == FuncLoad && $urandom_range(0, 3) != 0)
                ev.preset_in = 10'($urandom_range(0, 40));
            send_event(ev, 1'b0, '0);
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 20);
                if (gap_max > 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
                end
            end
        end
    endtask

    // receiver stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        rx_cycles++;
        if (rx_cycles % 48 == 0)
            rx_style = $urandom_range(0, 3);
        if (hold_req) begin
            hold_left = 150;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_style)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ~i_out_ready;
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frames_due.size() == 0) begin
                report_mismatch("unexpected result, count_out",
                                longint'(o_out_item.count_out), longint'(0));
            end else begin
                want = frames_due.pop_front();
                check_field("port_a_out", 16'(o_out_item.port_a_out), 16'(want.port_a_out));
                check_field("port_b_out", 16'(o_out_item.port_b_out), 16'(want.port_b_out));
                check_field("port_c_out", 16'(o_out_item.port_c_out), 16'(want.port_c_out));
                check_field("port_d_out", 16'(o_out_item.port_d_out), 16'(want.port_d_out));
                check_field("port_d_dir", 16'(o_out_item.port_d_dir), 16'(want.port_d_dir));
                check_field("mode_out", 16'(o_out_item.mode_out), 16'(want.mode_out));
                check_field("count_out", 16'(o_out_item.count_out), 16'(want.count_out));
                check_field("save_valid", 16'(o_out_item.save_valid), 16'(want.save_valid));
                check_field("save_value", 16'(o_out_item.save_value), 16'(want.save_value));
            end
        end
    end

    // main sequence
    initial begin
        t_in_item  ev;
        t_out_item typed_frame;
        logic [15:0] cnt_val;
        logic [15:0] blk_val;
        int gap_max;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed events under the reset intervals
        for (int r = 0; r < DirRows; r++) begin
            ev.func = DirTab[r].func;
            ev.preset_in = DirTab[r].pin;
            typed_frame = '0;
            typed_frame.mode_out = DirTab[r].mode;
            typed_frame.count_out = DirTab[r].count;
            send_event(ev, DirTab[r].typed, typed_frame);
        end

        // random phases, each under its own interval setting
        for (int p = 0; p < 5; p++) begin
            drain_frames();
            gap_max = 6;
            case (p)
                0: begin cnt_val = 16'd1; blk_val = 16'd1; end
                1: begin cnt_val = 16'hFFFF; blk_val = 16'hFFFF; end
                2: begin cnt_val = 16'd2; blk_val = 16'd5; end
                3: begin
                    cnt_val = 16'($urandom_range(1, 6));
                    blk_val = 16'($urandom_range(1, 12));
                    gap_max = 0;
                end
                default: begin cnt_val = 16'd1; blk_val = 16'd3; end
            endcase
            cfg_write(RegCountInterval, cnt_val);
            cfg_write(RegBlinkInterval, blk_val);
            // output held off while events keep coming, so the input stalls
            if (p == 1) begin
                hold_req = 1'b1;
                send_random(40, 0);
            end
            send_random(152, gap_max);
        end

        drain_frames();
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ctdc_pkg.sv
hw/rtl/ctdc_apb.sv
hw/rtl/ctdc_scan.sv
hw/rtl/ctdc_ctrl.sv
hw/rtl/countdown_timer_display_controller_core.sv
sim/tb_top.sv
